// ===== rtl/core/wlss_pkg.sv =====
// Shared types and constants for the work-group local size selector.
package wlss_pkg;

  localparam int MAXG_W  = 11;
  localparam int SUB_W   = 8;
  localparam int CU_W    = 7;
  localparam int MODEL_W = 10;
  localparam int COUNT_W = CU_W + 1;
  localparam int OUT_W   = 11;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [MODEL_W-1:0] MODEL_DOUBLE_AT = MODEL_W'(540);

  localparam logic [MAXG_W-1:0]  MAXG_RESET  = MAXG_W'(256);
  localparam logic [SUB_W-1:0]   SUB_RESET   = '0;
  localparam logic [CU_W-1:0]    CU_RESET    = CU_W'(1);
  localparam logic [MODEL_W-1:0] MODEL_RESET = '0;

  typedef enum logic [1:0] {
    REG_MAX_GROUP     = 2'd0,
    REG_SUBGROUP      = 2'd1,
    REG_COMPUTE_UNITS = 2'd2,
    REG_DEVICE_MODEL  = 2'd3
  } reg_idx_t;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_FIX  = 9'b000000010,
    S_HI   = 9'b000000100,
    S_LO   = 9'b000001000,
    S_CAND = 9'b000010000,
    S_SUB  = 9'b000100000,
    S_GX   = 9'b001000000,
    S_GY   = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

endpackage

// ===== rtl/core/wlss_chan_if.sv =====
// Valid/ready channel interfaces for the request and the result of the selector.
interface wlss_cmd_if
  import wlss_pkg::*;
#(
  parameter int GLOBAL_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [GLOBAL_BITS-1:0] global_x;
  logic [GLOBAL_BITS-1:0] global_y;

  modport source (output valid, output global_x, output global_y, input ready);
  modport sink   (input valid, input global_x, input global_y, output ready);
endinterface

interface wlss_res_if
  import wlss_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             found;
  logic [OUT_W-1:0] local_x;
  logic [OUT_W-1:0] local_y;

  modport source (output valid, output found, output local_x, output local_y, input ready);
  modport sink   (input valid, input found, input local_x, input local_y, output ready);
endinterface

// ===== rtl/core/wlss_div.sv =====
// Radix-2 restoring divider that produces one quotient bit per cycle.
module wlss_div #(
  parameter int DW = 22,
  parameter int BW = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [BW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quot,
  output logic [BW-1:0] rem
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    quo;
  logic [BW:0]      r;
  logic [BW-1:0]    dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done_q;

  logic [BW:0] r_sh;
  logic        ge;
  logic [BW:0] diff;

  always_comb begin
    r_sh = {r[BW-1:0], quo[DW-1]};
    ge   = r_sh >= {1'b0, dvs};
    diff = r_sh - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_q <= 1'b0;
      cnt    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DW);
        quo  <= dividend;
        dvs  <= divisor;
        r    <= '0;
      end else if (busy) begin
        r   <= ge ? diff : r_sh;
        quo <= {quo[DW-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy   <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done = done_q;
  assign quot = quo;
  assign rem  = r[BW-1:0];

endmodule

// ===== rtl/core/workgroup_local_size_select.sv =====
// Top level of the work-group local size selector: registers, sequencer and result stage.
//
//   channel  | direction | handshake      | payload
//   ---------+-----------+----------------+----------------------------------
//   cmd      | in        | valid/ready    | global_x, global_y
//   res      | out       | valid/ready    | found, local_x, local_y
//   apb      | in        | psel/penable   | paddr, pwdata -> prdata (4 regs)
//
// Every modulo and quotient runs through one shared restoring divider.
// A transaction takes up to three divisions per axis for setup and up to three
// divisions per tested candidate, so its length depends on the data.
// Reset is synchronous and active high; it restores the register defaults and idles.
// cmd.ready is high only while the sequencer is idle; a finished result waits in the
// output register, and the next transaction is taken while it is still unclaimed.
module workgroup_local_size_select
  import wlss_pkg::*;
#(
  parameter int MAX_GROUP_LIMIT = 1024,
  parameter int GLOBAL_BITS     = 16
) (
  input  logic              clk,
  input  logic              rst,
  wlss_cmd_if.sink          cmd,
  wlss_res_if.source        res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // Local sizes never exceed the clamped group limit.
  localparam int LW = $clog2(MAX_GROUP_LIMIT + 1);
  // Candidate counter also holds the lower search bound (up to 2 * 255).
  localparam int VW = (LW > 9) ? LW : 9;
  localparam int PW = 2 * LW;
  localparam int DW = (GLOBAL_BITS > PW) ? GLOBAL_BITS : PW;
  localparam int BW = (LW > SUB_W) ? LW : SUB_W;
  localparam int GB = GLOBAL_BITS;

  // Configuration registers.
  logic [MAXG_W-1:0]  cfg_max;
  logic [SUB_W-1:0]   cfg_sub;
  logic [CU_W-1:0]    cfg_cu;
  logic [MODEL_W-1:0] cfg_model;

  logic wr_en;
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_max   <= MAXG_RESET;
      cfg_sub   <= SUB_RESET;
      cfg_cu    <= CU_RESET;
      cfg_model <= MODEL_RESET;
    end else if (wr_en) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_MAX_GROUP:     cfg_max   <= pwdata[MAXG_W-1:0];
        REG_SUBGROUP:      cfg_sub   <= pwdata[SUB_W-1:0];
        REG_COMPUTE_UNITS: cfg_cu    <= pwdata[CU_W-1:0];
        REG_DEVICE_MODEL:  cfg_model <= pwdata[MODEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_MAX_GROUP:     prdata = DATA_W'(cfg_max);
      REG_SUBGROUP:      prdata = DATA_W'(cfg_sub);
      REG_COMPUTE_UNITS: prdata = DATA_W'(cfg_cu);
      REG_DEVICE_MODEL:  prdata = DATA_W'(cfg_model);
      default:           prdata = '0;
    endcase
  end

  // Effective device limits: the group size is clamped to 1..MAX_GROUP_LIMIT, and
  // the minimum group count doubles on newer device models.
  logic [LW-1:0]      maxg_c;
  logic [CU_W-1:0]    cu_eff;
  logic [COUNT_W-1:0] count_c;

  always_comb begin
    if (cfg_max == '0) begin
      maxg_c = LW'(1);
    end else if (32'(cfg_max) > MAX_GROUP_LIMIT) begin
      maxg_c = LW'(MAX_GROUP_LIMIT);
    end else begin
      maxg_c = LW'(cfg_max);
    end
    cu_eff  = (cfg_cu == '0) ? CU_W'(1) : cfg_cu;
    count_c = (cfg_model >= MODEL_DOUBLE_AT) ? {cu_eff, 1'b0} : {1'b0, cu_eff};
  end

  // Shared divider.
  logic          dstart;
  logic [DW-1:0] da;
  logic [BW-1:0] db;
  logic          div_done;
  logic [DW-1:0] div_q;
  logic [BW-1:0] div_r;

  wlss_div #(
    .DW (DW),
    .BW (BW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dstart),
    .dividend (da),
    .divisor  (db),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  // Sequencer state. axis is low while y is the fixed axis, high once x is.
  state_t             state;
  logic               axis;
  logic               fb;
  logic [GB-1:0]      gx;
  logic [GB-1:0]      gy;
  logic [LW-1:0]      maxg;
  logic [SUB_W-1:0]   sub;
  logic [COUNT_W-1:0] count;
  logic [LW-1:0]      fixed;
  logic [VW-1:0]      vstart;
  logic [VW-1:0]      lo;
  logic [VW-1:0]      v;
  logic               found_r;
  logic [LW-1:0]      lx_r;
  logic [LW-1:0]      ly_r;

  // Output register.
  logic             ovalid;
  logic             out_found;
  logic [OUT_W-1:0] out_x;
  logic [OUT_W-1:0] out_y;

  logic [GB-1:0] gvar;
  logic [LW-1:0] cand_x;
  logic [LW-1:0] cand_y;
  logic [PW-1:0] prod_c;
  logic          order_ok;
  logic [LW-1:0] fixed_c;
  logic [DW-1:0] vmin_w;
  logic [VW-1:0] vstart_c;
  logic [VW-1:0] lo_c;
  logic          div_wait;
  logic          reject;
  logic          axis_fail;
  logic [LW+OUT_W-1:0] lx_ext;
  logic [LW+OUT_W-1:0] ly_ext;

  always_comb begin
    gvar     = axis ? gy : gx;
    cand_x   = axis ? fixed : v[LW-1:0];
    cand_y   = axis ? v[LW-1:0] : fixed;
    prod_c   = cand_x * cand_y;
    // The shape of the group has to follow the shape of the global range.
    order_ok = (cand_x < cand_y) == (gx < gy);

    if (div_q == '0) begin
      fixed_c = '0;
    end else if (div_q > DW'(maxg)) begin
      fixed_c = maxg;
    end else begin
      fixed_c = div_q[LW-1:0];
    end

    // Upper search bound and fallback value: min(free global size, maxg / fixed).
    vmin_w   = (DW'(gvar) < div_q) ? DW'(gvar) : div_q;
    vstart_c = vmin_w[VW-1:0];
    lo_c     = (div_q == '0) ? VW'(1) : div_q[VW-1:0];

    div_wait = (state == S_FIX) || (state == S_HI) || (state == S_LO) ||
               (state == S_SUB) || (state == S_GX) || (state == S_GY);

    // A candidate fails on the shape test or on any nonzero remainder.
    reject = ((state == S_CAND) && !(!fb && (v < lo)) && !order_ok) ||
             (div_done && ((state == S_SUB) || (state == S_GX) || (state == S_GY)) &&
              (div_r != '0));

    // An axis is given up when its global size does not split evenly into the
    // minimum count, when the split is empty, or when the fallback candidate fails.
    axis_fail = (reject && fb) ||
                ((state == S_FIX) && div_done && ((div_r != '0) || (fixed_c == '0)));
  end

  assign cmd.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      dstart <= 1'b0;
      ovalid <= 1'b0;
      axis   <= 1'b0;
      fb     <= 1'b0;
    end else begin
      dstart <= 1'b0;
      if (ovalid && res.ready) begin
        ovalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            gx    <= cmd.global_x;
            gy    <= cmd.global_y;
            maxg  <= maxg_c;
            count <= count_c;
            sub   <= cfg_sub;
            axis  <= 1'b0;
            if ((cmd.global_x == '0) || (cmd.global_y == '0)) begin
              found_r <= 1'b0;
              lx_r    <= '0;
              ly_r    <= '0;
              state   <= S_DONE;
            end else begin
              // y is fixed first: divide global_y by the minimum group count.
              da     <= DW'(cmd.global_y);
              db     <= BW'(count_c);
              dstart <= 1'b1;
              state  <= S_FIX;
            end
          end
        end

        S_FIX: begin
          if (div_done) begin
            fixed  <= fixed_c;
            da     <= DW'(maxg);
            db     <= BW'(fixed_c);
            dstart <= 1'b1;
            state  <= S_HI;
          end
        end

        S_HI: begin
          if (div_done) begin
            vstart <= vstart_c;
            if (sub == '0) begin
              // Without a subgroup width only the fallback candidate is tried.
              fb    <= 1'b1;
              v     <= vstart_c;
              state <= S_CAND;
            end else begin
              fb     <= 1'b0;
              da     <= DW'({sub, 1'b0});
              db     <= BW'(fixed);
              dstart <= 1'b1;
              state  <= S_LO;
            end
          end
        end

        S_LO: begin
          if (div_done) begin
            lo    <= lo_c;
            v     <= vstart;
            state <= S_CAND;
          end
        end

        S_CAND: begin
          if (!fb && (v < lo)) begin
            // Search exhausted; retry the top candidate without the subgroup test.
            fb <= 1'b1;
            v  <= vstart;
          end else if (order_ok) begin
            dstart <= 1'b1;
            if (!fb) begin
              da    <= DW'(prod_c);
              db    <= BW'(sub);
              state <= S_SUB;
            end else begin
              da    <= DW'(gx);
              db    <= BW'(cand_x);
              state <= S_GX;
            end
          end
        end

        S_SUB: begin
          if (div_done) begin
            da     <= DW'(gx);
            db     <= BW'(cand_x);
            dstart <= 1'b1;
            state  <= S_GX;
          end
        end

        S_GX: begin
          if (div_done) begin
            da     <= DW'(gy);
            db     <= BW'(cand_y);
            dstart <= 1'b1;
            state  <= S_GY;
          end
        end

        S_GY: begin
          if (div_done) begin
            found_r <= 1'b1;
            lx_r    <= cand_x;
            ly_r    <= cand_y;
            state   <= S_DONE;
          end
        end

        S_DONE: begin
          if (!ovalid || res.ready) begin
            out_found <= found_r;
            out_x     <= lx_ext[OUT_W-1:0];
            out_y     <= ly_ext[OUT_W-1:0];
            ovalid    <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase

      // Failure handling overrides the normal step taken above.
      if (axis_fail) begin
        dstart <= 1'b0;
        if (!axis) begin
          axis   <= 1'b1;
          da     <= DW'(gx);
          db     <= BW'(count);
          dstart <= 1'b1;
          state  <= S_FIX;
        end else begin
          found_r <= 1'b0;
          lx_r    <= '0;
          ly_r    <= '0;
          state   <= S_DONE;
        end
      end else if (reject) begin
        dstart <= 1'b0;
        v      <= v - 1'b1;
        state  <= S_CAND;
      end
    end
  end

  assign lx_ext = (LW + OUT_W)'(lx_r);
  assign ly_ext = (LW + OUT_W)'(ly_r);

  assign res.valid   = ovalid;
  assign res.found   = out_found;
  assign res.local_x = out_x;
  assign res.local_y = out_y;

  a_fixed_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CAND) |-> (fixed != '0) && (fixed <= maxg))
    else $error("fixed axis size out of range during candidate test");

  a_search_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_CAND) && !fb |-> (v <= vstart) && (lo != '0))
    else $error("candidate outside search window");

  a_found_sizes: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && found_r |-> (lx_r != '0) && (ly_r != '0))
    else $error("found result with empty local size");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && !found_r |-> (lx_r == '0) && (ly_r == '0))
    else $error("failed search left nonzero local size");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> div_wait)
    else $error("divider finished outside a waiting state");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the work-group local size selector.
module testbench;
  import wlss_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 11;
  localparam int GLOBAL_W     = 16;
  localparam int GROUP_LIMIT  = 1024;
  // A model number at or above MODEL_DOUBLE_AT multiplies the group count by this.
  localparam int COUNT_FACTOR = 2;
  // Cost control: a request whose candidate search is longer than this is drawn
  // again, except for a handful of slow requests that are let through on purpose.
  localparam int PROBE_CAP    = 16;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 200;
  // Watchdog limit for the whole run, in simulation time units.
  localparam longint TIMEOUT  = 100_000_000;

  typedef struct packed {
    logic [GLOBAL_W-1:0] global_x;
    logic [GLOBAL_W-1:0] global_y;
  } global_size_t;

  typedef struct packed {
    logic             found;
    logic [OUT_W-1:0] local_x;
    logic [OUT_W-1:0] local_y;
  } local_size_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  wlss_cmd_if #(.GLOBAL_BITS(GLOBAL_W)) cmd_ch ();
  wlss_res_if                            res_ch ();

  workgroup_local_size_select #(
    .MAX_GROUP_LIMIT(GROUP_LIMIT),
    .GLOBAL_BITS    (GLOBAL_W)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_ch),
    .res    (res_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Shadow copy of the device settings, updated on every register write.
  logic [MAXG_W-1:0]  cfg_max_group     = MAXG_RESET;
  logic [SUB_W-1:0]   cfg_subgroup      = SUB_RESET;
  logic [CU_W-1:0]    cfg_compute_units = CU_RESET;
  logic [MODEL_W-1:0] cfg_device_model  = MODEL_RESET;

  // Requests waiting to be driven, and local sizes waiting to come out.
  global_size_t queued_global_sizes[$];
  local_size_t  expected_local_sizes[$];

  global_size_t next_request;
  local_size_t  seen_size;
  local_size_t  wanted_size;
  int           probe_scratch;

  int issued_count   = 0;
  int accepted_count = 0;
  int fail_count     = 0;
  int send_gap       = 0;
  int hold_cycles    = 0;
  int slow_left      = 3;
  bit request_taken  = 1'b0;
  bit idle_on        = 1'b1;
  bit long_hold_req  = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Minimum number of work groups: compute units (zero counts as one), doubled
  // on newer device models.
  function automatic int effective_group_count();
    int count;
    count = (cfg_compute_units == '0) ? 1 : int'(cfg_compute_units);
    if (cfg_device_model >= MODEL_DOUBLE_AT) count = COUNT_FACTOR * count;
    return count;
  endfunction

  // Both local sizes divide their global sizes, and the x-versus-y ordering
  // matches that of the global sizes.
  function automatic bit sizes_divide(input int x, input int y, input int gx, input int gy);
    return (gx % x == 0) && (gy % y == 0) && ((x < y) == (gx < gy));
  endfunction

  // Fix one axis from its global size divided by the group count, then look for
  // the other axis: downward search with the subgroup test, then one clamped fallback.
  function automatic bit try_fixed_axis(input int gfix, input int gvar, input bit fix_is_y,
                                        input int gx, input int gy, input int count,
                                        input int maxg, input int sub,
                                        output int lx, output int ly, inout int probes);
    int anchor, top, bottom, v, x, y;
    lx = 0;
    ly = 0;
    if (gfix % count != 0) return 1'b0;
    anchor = gfix / count;
    if (anchor > maxg) anchor = maxg;
    if (anchor == 0) return 1'b0;
    if (sub != 0) begin
      top = maxg / anchor;
      if (top < 1) top = 1;
      bottom = (COUNT_FACTOR * sub) / anchor;
      if (bottom < 1) bottom = 1;
      for (v = (gvar < top) ? gvar : top; v >= bottom; v--) begin
        probes++;
        x = fix_is_y ? v : anchor;
        y = fix_is_y ? anchor : v;
        if ((x * y) % sub == 0 && sizes_divide(x, y, gx, gy)) begin
          lx = x;
          ly = y;
          return 1'b1;
        end
      end
    end
    v = maxg / anchor;
    if (gvar < v) v = gvar;
    if (v < 1) v = 1;
    x = fix_is_y ? v : anchor;
    y = fix_is_y ? anchor : v;
    if (sizes_divide(x, y, gx, gy)) begin
      lx = x;
      ly = y;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Expected local size for one request under the current settings. The number of
  // candidates tested is handed back so that the stimulus can keep runs short.
  function automatic local_size_t predict_local_size(input logic [GLOBAL_W-1:0] gx_in,
                                                     input logic [GLOBAL_W-1:0] gy_in,
                                                     output int probes);
    int gx, gy, maxg, count, lx, ly;
    bit ok;
    local_size_t r;
    gx = int'(gx_in);
    gy = int'(gy_in);
    maxg = int'(cfg_max_group);
    if (maxg < 1) maxg = 1;
    if (maxg > GROUP_LIMIT) maxg = GROUP_LIMIT;
    count = effective_group_count();
    probes = 0;
    ok = 1'b0;
    lx = 0;
    ly = 0;
    if (gx != 0 && gy != 0) begin
      ok = try_fixed_axis(gy, gx, 1'b1, gx, gy, count, maxg, int'(cfg_subgroup), lx, ly, probes);
      if (!ok)
        ok = try_fixed_axis(gx, gy, 1'b0, gx, gy, count, maxg, int'(cfg_subgroup),
                            lx, ly, probes);
    end
    r.found   = ok;
    r.local_x = ok ? OUT_W'(lx) : '0;
    r.local_y = ok ? OUT_W'(ly) : '0;
    return r;
  endfunction

  // One APB transfer: setup cycle, then access cycle until pready.
  task automatic apb_access(input reg_idx_t idx, input bit is_write,
                            input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write a register, update the shadow copy, and read the register back.
  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] stored, readback;
    case (idx)
      REG_MAX_GROUP: begin
        cfg_max_group = value[MAXG_W-1:0];
        stored = DATA_W'(cfg_max_group);
      end
      REG_SUBGROUP: begin
        cfg_subgroup = value[SUB_W-1:0];
        stored = DATA_W'(cfg_subgroup);
      end
      REG_COMPUTE_UNITS: begin
        cfg_compute_units = value[CU_W-1:0];
        stored = DATA_W'(cfg_compute_units);
      end
      default: begin
        cfg_device_model = value[MODEL_W-1:0];
        stored = DATA_W'(cfg_device_model);
      end
    endcase
    apb_access(idx, 1'b1, value, readback);
    apb_access(idx, 1'b0, '0, readback);
    if (readback !== stored) begin
      $display("%0t: register %s readback mismatch: expected %0d, actual %0d",
               $time, idx.name(), stored, readback);
      fail_count++;
    end
  endtask

  task automatic write_settings(input int maxg, input int sub, input int cu, input int model);
    write_reg(REG_MAX_GROUP, DATA_W'(maxg));
    write_reg(REG_SUBGROUP, DATA_W'(sub));
    write_reg(REG_COMPUTE_UNITS, DATA_W'(cu));
    write_reg(REG_DEVICE_MODEL, DATA_W'(model));
  endtask

  // Random settings, biased toward the interesting corners of each register.
  task automatic randomize_settings();
    int maxg, sub, cu, model;
    case ($urandom_range(0, 5))
      0:       maxg = 0;
      1:       maxg = $urandom_range(1025, 2047);
      2:       maxg = 1 << $urandom_range(0, 10);
      default: maxg = $urandom_range(1, 1024);
    endcase
    case ($urandom_range(0, 4))
      0:       sub = 0;
      1:       sub = 1 << $urandom_range(0, 7);
      2:       sub = $urandom_range(129, 255);
      3:       sub = 1 << $urandom_range(2, 5);
      default: sub = $urandom_range(1, 128);
    endcase
    case ($urandom_range(0, 3))
      0:       cu = 1 << $urandom_range(0, 6);
      1:       cu = 0;
      2:       cu = $urandom_range(1, 4);
      default: cu = $urandom_range(0, 127);
    endcase
    case ($urandom_range(0, 3))
      0:       model = $urandom_range(0, 539);
      1:       model = $urandom_range(540, 1023);
      2:       model = $urandom_range(539, 540);
      default: model = $urandom_range(0, 1023);
    endcase
    write_settings(maxg, sub, cu, model);
  endtask

  function automatic logic [GLOBAL_W-1:0] edge_global();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return GLOBAL_W'(1);
      2:       return '1;
      3:       return '1 - GLOBAL_W'(1);
      4:       return GLOBAL_W'(1) << $urandom_range(0, GLOBAL_W - 1);
      default: return GLOBAL_W'($urandom_range(2, 8));
    endcase
  endfunction

  // Most requests are shaped so that one axis divides by the group count and the
  // other is rich in small factors, which gets the search to pass candidates. The
  // rest are full-range noise, tiny sizes and edge values.
  function automatic global_size_t draw_global_size(input int count);
    global_size_t g;
    int f, other;
    f = (1 << $urandom_range(0, 6)) * $urandom_range(1, 3);
    other = (1 << $urandom_range(0, 10)) * $urandom_range(1, 5);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        g.global_y = (count * f <= 65535) ? GLOBAL_W'(count * f) : GLOBAL_W'(count);
        g.global_x = GLOBAL_W'(other);
      end
      4, 5: begin
        g.global_x = (count * f <= 65535) ? GLOBAL_W'(count * f) : GLOBAL_W'(count);
        g.global_y = GLOBAL_W'(other);
      end
      6, 7: begin
        g.global_x = GLOBAL_W'($urandom_range(0, 65535));
        g.global_y = GLOBAL_W'($urandom_range(0, 65535));
      end
      8: begin
        g.global_x = GLOBAL_W'($urandom_range(1, 64));
        g.global_y = GLOBAL_W'($urandom_range(1, 64));
      end
      default: begin
        g.global_x = edge_global();
        g.global_y = edge_global();
      end
    endcase
    return g;
  endfunction

  task automatic queue_random_sizes(input int n);
    global_size_t g;
    int probes, tries;
    bit ok;
    repeat (n) begin
      ok = 1'b0;
      for (tries = 0; tries < 40 && !ok; tries++) begin
        g = draw_global_size(effective_group_count());
        void'(predict_local_size(g.global_x, g.global_y, probes));
        if (probes <= PROBE_CAP) begin
          ok = 1'b1;
        end else if (slow_left > 0 && $urandom_range(0, 49) == 0) begin
          slow_left--;
          ok = 1'b1;
        end
      end
      // A unit request never needs more than one candidate per axis.
      if (!ok) g = '{GLOBAL_W'(1), GLOBAL_W'(1)};
      queued_global_sizes.push_back(g);
    end
  endtask

  // Edge values of both sizes, zero sizes, and requests that pass on either axis.
  task automatic queue_directed_sizes();
    queued_global_sizes.push_back('{GLOBAL_W'(1), GLOBAL_W'(1)});
    queued_global_sizes.push_back('{'1, '1});
    queued_global_sizes.push_back('{GLOBAL_W'(0), GLOBAL_W'(9)});
    queued_global_sizes.push_back('{GLOBAL_W'(9), GLOBAL_W'(0)});
    queued_global_sizes.push_back('{GLOBAL_W'(1024), GLOBAL_W'(16)});
    queued_global_sizes.push_back('{GLOBAL_W'(16), GLOBAL_W'(1024)});
    queued_global_sizes.push_back('{GLOBAL_W'(640), GLOBAL_W'(480)});
  endtask

  // Every item produces exactly one result, so once nothing is queued, in flight or
  // outstanding the selector is idle and its registers may be written.
  task automatic wait_drained();
    while (queued_global_sizes.size() != 0 || issued_count != accepted_count ||
           expected_local_sizes.size() != 0)
      @(negedge clk);
  endtask

  // Request driver. A request stays on the bus until it is taken; between requests
  // the sender sometimes goes quiet for a burst of cycles.
  always @(negedge clk) begin
    if (rst) begin
      cmd_ch.valid    <= 1'b0;
      cmd_ch.global_x <= '0;
      cmd_ch.global_y <= '0;
    end else if (!cmd_ch.valid || request_taken) begin
      request_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        cmd_ch.valid <= 1'b0;
      end else if (queued_global_sizes.size() != 0) begin
        next_request = queued_global_sizes.pop_front();
        cmd_ch.valid    <= 1'b1;
        cmd_ch.global_x <= next_request.global_x;
        cmd_ch.global_y <= next_request.global_y;
        issued_count++;
        if (idle_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 15);
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver. Short random stalls, plus one long hold-off on request that
  // backs the selector up until it refuses new requests.
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_cycles = LONG_HOLD;
      end else if (hold_cycles == 0 && idle_on && $urandom_range(0, 7) == 0) begin
        hold_cycles = $urandom_range(1, 15);
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor. Results are checked in order against the predictions made when the
  // matching request transaction was accepted.
  always @(posedge clk) begin
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        seen_size = '{res_ch.found, res_ch.local_x, res_ch.local_y};
        if (expected_local_sizes.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual found=%0d x=%0d y=%0d",
                   $time, seen_size.found, seen_size.local_x, seen_size.local_y);
          fail_count++;
        end else begin
          wanted_size = expected_local_sizes.pop_front();
          if (seen_size.found !== wanted_size.found ||
              seen_size.local_x !== wanted_size.local_x ||
              seen_size.local_y !== wanted_size.local_y) begin
            $display("%0t: mismatch: expected found=%0d x=%0d y=%0d, actual found=%0d x=%0d y=%0d",
                     $time, wanted_size.found, wanted_size.local_x, wanted_size.local_y,
                     seen_size.found, seen_size.local_x, seen_size.local_y);
            fail_count++;
          end
        end
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        expected_local_sizes.push_back(
          predict_local_size(cmd_ch.global_x, cmd_ch.global_y, probe_scratch));
        accepted_count++;
        request_taken = 1'b1;
      end
    end
  end

  // Main sequence: directed requests under reset and three corner settings, then random
  // requests under fixed, then random settings; the last phase runs without idling.
  initial begin
    rst     = 1'b1;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    queue_directed_sizes();
    wait_drained();

    write_settings(1024, 32, 4, 600);
    queue_directed_sizes();
    wait_drained();

    // Zero group size and zero compute units, model just below the doubling point.
    write_settings(0, 0, 0, 539);
    queue_directed_sizes();
    wait_drained();

    // Every register at its all-ones value; the group size is clamped to the limit.
    write_settings(2047, 255, 127, 1023);
    queue_directed_sizes();
    wait_drained();

    write_settings(1, 1, 1, 540);
    queue_random_sizes(60);
    wait_drained();

    for (int phase = 0; phase < 8; phase++) begin
      randomize_settings();
      idle_on = (phase == 7) ? 1'b0 : ($urandom_range(0, 3) != 0);
      queue_random_sizes(70);
      if (phase == 1) long_hold_req = 1'b1;
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(TIMEOUT);
    $display("%0t: timeout with %0d results outstanding", $time, expected_local_sizes.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
